/* rtl/core/ddo_pkg.sv */
// Shared types, constants and helper functions for the odometry block.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] REG_INV_BASE     = 2'd1;

  // Register reset values.
  localparam logic [19:0] RADIUS_RESET   = 20'd3277;
  localparam logic [23:0] INV_BASE_RESET = 24'd327680;

  // The arctangent table has this many entries.
  localparam int unsigned MAX_STAGES = 24;

  // Gain-compensated CORDIC start value, Q2.30.
  localparam logic signed [33:0] CORDIC_START = 34'sd652032875;

  // 65536 / (2*pi) in Q16.
  localparam logic signed [30:0] RAD_TO_BAM = 31'sd683565276;

  // Signed 32-bit limits in product width.
  localparam logic signed [70:0] S32_MAX = 71'sd2147483647;
  localparam logic signed [70:0] S32_MIN = -71'sd2147483648;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIFF,
    ST_W37,
    ST_WIB,
    ST_VDT,
    ST_WDT,
    ST_PLO,
    ST_PHI,
    ST_TURN,
    ST_WAIT,
    ST_DX,
    ST_DY,
    ST_Y,
    ST_DONE
  } state_t;

  // Operand pairs for the shared multiplier.
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_R_SUM,
    MUL_R_DIFF,
    MUL_W_IB,
    MUL_V_DT,
    MUL_W_DT,
    MUL_PLO_K,
    MUL_PHI_K,
    MUL_D_C,
    MUL_D_S
  } mul_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    mul_op_t mul_op;
    logic    ld_v;
    logic    ld_w37;
    logic    ld_w;
    logic    ld_d;
    logic    ld_phi;
    logic    ld_lo;
    logic    ld_head;
    logic    ld_x;
    logic    ld_y;
    logic    ld_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cordic_done;
  } sts_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to signed 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [70:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/ddo_cordic.sv */
// Iterative rotation-mode CORDIC giving cos and sin of a 16-bit binary angle.
`timescale 1ns / 1ps
`default_nettype none
module ddo_cordic #(
  parameter int unsigned STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [15:0]        angle,
  output logic                    done,
  output logic signed [17:0]      cos_out,
  output logic signed [17:0]      sin_out
);
  import ddo_pkg::*;

  localparam int unsigned CW = $clog2(STAGES);

  logic               busy;
  logic [CW-1:0]      cnt;
  logic               flip;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic [31:0]        a_full;
  logic               flip_start;
  logic signed [19:0] x_rnd;
  logic signed [19:0] y_rnd;

  // Angle folding: second and third quarter turns rotate by half a turn.
  always_comb begin
    a_full     = {angle, 16'd0};
    flip_start = (a_full[31:30] == 2'b01) || (a_full[31:30] == 2'b10);
  end

  // Shifted terms and table entry for the current iteration.
  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
    at = 34'($signed({1'b0, atan_bam(5'(cnt))}));
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == CW'(STAGES - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // One rotation step per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      flip <= flip_start;
      x    <= CORDIC_START;
      y    <= '0;
      z    <= 34'($signed({a_full[31] ^ flip_start, a_full[30:0]}));
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  // Round to Q16 and undo the half-turn fold.
  always_comb begin
    x_rnd   = 20'((x + 34'sd8192) >>> 14);
    y_rnd   = 20'((y + 34'sd8192) >>> 14);
    cos_out = flip ? 18'(-x_rnd) : 18'(x_rnd);
    sin_out = flip ? 18'(-y_rnd) : 18'(y_rnd);
  end

endmodule
`default_nettype wire

/* rtl/core/ddo_datapath.sv */
// Odometry datapath: registers, shared multiplier, CORDIC and pose update.
`timescale 1ns / 1ps
`default_nettype none
module ddo_datapath #(
  parameter int unsigned STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ddo_pkg::cmd_t      cmd,
  output ddo_pkg::sts_t           sts,
  input  wire logic               write_enable,
  input  wire logic [1:0]         reg_index,
  input  wire logic [23:0]        write_data,
  input  wire logic signed [31:0] left_wheel_speed,
  input  wire logic signed [31:0] right_wheel_speed,
  input  wire logic [23:0]        time_step,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic [15:0]             heading
);
  import ddo_pkg::*;

  logic [19:0]        radius;
  logic [23:0]        inv_base;
  logic signed [32:0] sum;
  logic signed [32:0] diff;
  logic [23:0]        dt;
  logic signed [70:0] prod;
  logic signed [39:0] a_op;
  logic signed [30:0] b_op;
  logic signed [31:0] v;
  logic signed [36:0] w37;
  logic signed [31:0] w;
  logic signed [39:0] d;
  logic signed [27:0] phi;
  logic [57:0]        lo;
  logic signed [31:0] x_pos;
  logic signed [31:0] y_pos;
  logic [15:0]        head;
  logic [63:0]        turn_sum;
  logic signed [70:0] pos_sum;
  logic               cordic_done;
  logic signed [17:0] cos_v;
  logic signed [17:0] sin_v;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radius   <= RADIUS_RESET;
      inv_base <= INV_BASE_RESET;
    end else if (write_enable) begin
      if (reg_index == REG_WHEEL_RADIUS) begin
        radius <= write_data[19:0];
      end else if (reg_index == REG_INV_BASE) begin
        inv_base <= write_data;
      end
    end
  end

  // Input capture on transfer.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sum  <= 33'(left_wheel_speed) + 33'(right_wheel_speed);
      diff <= 33'(right_wheel_speed) - 33'(left_wheel_speed);
      dt   <= time_step;
    end
  end

  // Cosine and sine of the stored heading.
  ddo_cordic #(
    .STAGES(STAGES)
  ) u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.load_in),
    .angle  (head),
    .done   (cordic_done),
    .cos_out(cos_v),
    .sin_out(sin_v)
  );

  assign sts.cordic_done = cordic_done;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd.mul_op)
      MUL_R_SUM: begin
        a_op = 40'(sum);
        b_op = 31'($signed({1'b0, radius}));
      end
      MUL_R_DIFF: begin
        a_op = 40'(diff);
        b_op = 31'($signed({1'b0, radius}));
      end
      MUL_W_IB: begin
        a_op = 40'(w37);
        b_op = 31'($signed({1'b0, inv_base}));
      end
      MUL_V_DT: begin
        a_op = 40'(v);
        b_op = 31'($signed({1'b0, dt}));
      end
      MUL_W_DT: begin
        a_op = 40'(w);
        b_op = 31'($signed({1'b0, dt}));
      end
      MUL_PLO_K: begin
        a_op = 40'($signed({1'b0, prod[27:0]}));
        b_op = RAD_TO_BAM;
      end
      MUL_PHI_K: begin
        a_op = 40'(phi);
        b_op = RAD_TO_BAM;
      end
      MUL_D_C: begin
        a_op = d;
        b_op = 31'(cos_v);
      end
      MUL_D_S: begin
        a_op = d;
        b_op = 31'(sin_v);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk) begin
    prod <= a_op * b_op;
  end

  // Intermediate results taken from the product.
  always_ff @(posedge clk) begin
    if (cmd.ld_v) begin
      v <= sat32(prod >>> 17);
    end
    if (cmd.ld_w37) begin
      w37 <= prod[52:16];
    end
    if (cmd.ld_w) begin
      w <= sat32(prod >>> 16);
    end
    if (cmd.ld_d) begin
      d <= prod[55:16];
    end
    if (cmd.ld_phi) begin
      phi <= prod[55:28];
    end
    if (cmd.ld_lo) begin
      lo <= prod[57:0];
    end
  end

  // Turn in binary angle units and position sum.
  always_comb begin
    turn_sum = {prod[35:0], 28'd0} + {6'd0, lo};
    pos_sum  = (cmd.ld_x ? 71'(x_pos) : 71'(y_pos)) + 71'($signed(prod[57:16]));
  end

  // Pose state.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos <= '0;
      y_pos <= '0;
      head  <= '0;
    end else begin
      if (cmd.ld_head) begin
        head <= head + turn_sum[63:48];
      end
      if (cmd.ld_x) begin
        x_pos <= sat32(pos_sum);
      end
      if (cmd.ld_y) begin
        y_pos <= sat32(pos_sum);
      end
    end
  end

  // Output registers.
  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      pos_x   <= x_pos;
      pos_y   <= y_pos;
      heading <= head;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ddo_ctrl.sv */
// Odometry controller: sequences the datapath and runs both handshakes.
`timescale 1ns / 1ps
`default_nettype none
module ddo_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire ddo_pkg::sts_t sts,
  output ddo_pkg::cmd_t      cmd
);
  import ddo_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ld_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_SUM;
      ST_SUM:  state_next = ST_DIFF;
      ST_DIFF: state_next = ST_W37;
      ST_W37:  state_next = ST_WIB;
      ST_WIB:  state_next = ST_VDT;
      ST_VDT:  state_next = ST_WDT;
      ST_WDT:  state_next = ST_PLO;
      ST_PLO:  state_next = ST_PHI;
      ST_PHI:  state_next = ST_TURN;
      ST_TURN: state_next = ST_WAIT;
      ST_WAIT: if (sts.cordic_done) state_next = ST_DX;
      ST_DX:   state_next = ST_DY;
      ST_DY:   state_next = ST_Y;
      ST_Y:    state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands for each state.
  always_comb begin
    cmd        = '0;
    cmd.mul_op = MUL_NONE;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
      end
      ST_SUM:  cmd.mul_op = MUL_R_SUM;
      ST_DIFF: begin
        cmd.ld_v   = 1'b1;
        cmd.mul_op = MUL_R_DIFF;
      end
      ST_W37:  cmd.ld_w37 = 1'b1;
      ST_WIB:  cmd.mul_op = MUL_W_IB;
      ST_VDT: begin
        cmd.ld_w   = 1'b1;
        cmd.mul_op = MUL_V_DT;
      end
      ST_WDT: begin
        cmd.ld_d   = 1'b1;
        cmd.mul_op = MUL_W_DT;
      end
      ST_PLO: begin
        cmd.ld_phi = 1'b1;
        cmd.mul_op = MUL_PLO_K;
      end
      ST_PHI: begin
        cmd.ld_lo  = 1'b1;
        cmd.mul_op = MUL_PHI_K;
      end
      ST_TURN: cmd.ld_head = 1'b1;
      ST_WAIT: cmd.mul_op = MUL_NONE;
      ST_DX:   cmd.mul_op = MUL_D_C;
      ST_DY: begin
        cmd.ld_x   = 1'b1;
        cmd.mul_op = MUL_D_S;
      end
      ST_Y:    cmd.ld_y = 1'b1;
      ST_DONE: cmd.ld_out = out_free;
      default: cmd.mul_op = MUL_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/diff_drive_odometry.sv */
// Top level of the differential drive odometry block.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------------
//   input   | in        | in_valid / in_stall  | left_wheel_speed, right_wheel_speed,
//           |           |                      | time_step
//   output  | out       | out_valid / out_stall| pos_x, pos_y, heading
//   config  | in        | write_enable         | reg_index, write_data
//
// The result is registered once the shared multiplier sequence and the CORDIC have both
// finished, and the next item is taken after the result has gone to the output register;
// the time an item takes is set by the iterative CORDIC (one stage a cycle, at most 24
// stages) and the shared multiplier sequence.
// Reset is synchronous and active high; it clears the pose and loads the register
// defaults. The next item is taken as soon as the pose is moved to the output
// register, so one result may wait under out_stall while the next item is computed.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_odometry #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] left_wheel_speed,
  input  wire logic signed [31:0] right_wheel_speed,
  input  wire logic [23:0]        time_step,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic [15:0]             heading,
  input  wire logic               write_enable,
  input  wire logic [1:0]         reg_index,
  input  wire logic [23:0]        write_data
);
  import ddo_pkg::*;

  localparam int unsigned STAGES =
    (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and state.
  ddo_datapath #(
    .STAGES(STAGES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .write_enable     (write_enable),
    .reg_index        (reg_index),
    .write_data       (write_data),
    .left_wheel_speed (left_wheel_speed),
    .right_wheel_speed(right_wheel_speed),
    .time_step        (time_step),
    .pos_x            (pos_x),
    .pos_y            (pos_y),
    .heading          (heading)
  );

endmodule
`default_nettype wire

/* rtl/core/ddo_checker.sv */
// Port-level checks for the odometry block and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ddo_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] pos_x,
  input wire logic [31:0] pos_y,
  input wire logic [15:0] heading
);

  // Reset leaves no result pending.
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // Reset leaves the block ready for an item.
  a_reset_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // After an input transfer the block is busy with that item.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item taken while busy");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading)))
    else $error("stalled result changed");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .pos_x    (pos_x),
  .pos_y    (pos_y),
  .heading  (heading)
);
`default_nettype wire
